[src/deq_pkg.sv]
// deq_pkg: shared types, codes and constants of the double-ended queue
// used by deq_front, deq_queue, deq_back and double_ended_queue
// no dependencies
package deq_pkg;

  // fixed field widths of the stream payloads
  localparam int CMD_W          = 3;
  localparam int VALUE_W        = 32;
  localparam int STATUS_W       = 2;
  localparam int COUNT_W        = 9;
  localparam int IN_TDATA_W     = 40;
  localparam int OUT_TDATA_W    = 48;

  // defaults handed to the top level parameters
  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 32;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH    = 2;

  // command codes carried by a request
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_FRONT      = 3'd4,
    CMD_BACK       = 3'd5,
    CMD_SIZE       = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_e_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_DATA  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  // classified request as it travels from front to back
  typedef struct packed {
    logic                      push;     // insert value
    logic                      read;     // return end value
    logic                      remove;   // read also drops the end value
    logic                      at_front; // which end the request acts on
    logic                      clear;    // empty the deque
    logic signed [VALUE_W-1:0] value;
  } op_t;

  // back end sequencing
  typedef enum logic {
    BK_EXEC,
    BK_RESP
  } bk_state_t;

endpackage

[src/deq_front.sv]
// deq_front: accepts requests from the input stream and classifies them
// depends on deq_pkg
module deq_front (
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [deq_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                        q_full,
  output logic                        q_push,
  output deq_pkg::op_t                q_op
);
  import deq_pkg::*;

  cmd_e_t cmd;

  // accept whenever the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign cmd       = cmd_e_t'(in_tdata[CMD_W-1:0]);

  // decode the command into action flags
  always_comb begin
    q_op          = '0;
    q_op.value    = $signed(in_tdata[CMD_W +: VALUE_W]);
    unique case (cmd)
      CMD_PUSH_FRONT: begin
        q_op.push     = 1'b1;
        q_op.at_front = 1'b1;
      end
      CMD_PUSH_BACK: begin
        q_op.push     = 1'b1;
      end
      CMD_POP_FRONT: begin
        q_op.read     = 1'b1;
        q_op.remove   = 1'b1;
        q_op.at_front = 1'b1;
      end
      CMD_POP_BACK: begin
        q_op.read     = 1'b1;
        q_op.remove   = 1'b1;
      end
      CMD_FRONT: begin
        q_op.read     = 1'b1;
        q_op.at_front = 1'b1;
      end
      CMD_BACK: begin
        q_op.read     = 1'b1;
      end
      CMD_SIZE: begin
        q_op.read     = 1'b0;
      end
      CMD_CLEAR: begin
        q_op.clear    = 1'b1;
      end
    endcase
  end

endmodule

[src/deq_queue.sv]
// deq_queue: short request queue between the front and the back end
// depends on deq_pkg
module deq_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  deq_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output deq_pkg::op_t pop_op
);
  import deq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_op    = slot_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_op;
  end

endmodule

[src/deq_back.sv]
// deq_back: ring of entries with head and tail pointers, executes requests
// and holds the result register; depends on deq_pkg
module deq_back #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_not_empty,
  input  deq_pkg::op_t                  q_op,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [deq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import deq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PAD_W = OUT_TDATA_W - STATUS_W - VALUE_W - COUNT_W;

  // ring storage
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  bk_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  status_t           pend_status_r, pend_status_nxt;
  logic [COUNT_W-1:0] pend_count_r, pend_count_nxt;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [VALUE_W-1:0] out_data_r;
  logic [COUNT_W-1:0] out_count_r;

  logic              exec_go;
  logic              out_load;
  logic              empty;
  logic              full;
  logic [IDX_W-1:0]  head_inc, head_dec, tail_inc, tail_dec;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [DATA_WIDTH-1:0] wr_word;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign head_inc = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
  assign tail_inc = (tail_r == IDX_W'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? IDX_W'(DEPTH - 1) : tail_r - 1'b1;
  assign wr_word  = DATA_WIDTH'($unsigned(q_op.value));

  // sequencing, pointer updates and memory control
  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    cnt_nxt         = cnt_r;
    pend_status_nxt = pend_status_r;
    pend_count_nxt  = pend_count_r;
    mem_we          = 1'b0;
    mem_waddr       = tail_r;
    mem_re          = 1'b0;
    mem_raddr       = head_r;

    out_load = (state_r == BK_RESP) && (!out_valid_r || out_tready);
    exec_go  = q_not_empty && ((state_r == BK_EXEC) || out_load);
    q_pop    = exec_go;

    if (out_load) state_nxt = BK_EXEC;

    if (exec_go) begin
      state_nxt       = BK_RESP;
      pend_status_nxt = ST_OK;
      priority if (q_op.clear) begin
        head_nxt = '0;
        tail_nxt = '0;
        cnt_nxt  = '0;
      end else if (q_op.push) begin
        if (full) begin
          pend_status_nxt = ST_ERROR;
        end else begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (q_op.at_front) begin
            head_nxt  = head_dec;
            mem_waddr = head_dec;
          end else begin
            mem_waddr = tail_r;
            tail_nxt  = tail_inc;
          end
        end
      end else if (q_op.read) begin
        if (empty) begin
          pend_status_nxt = ST_ERROR;
        end else begin
          pend_status_nxt = ST_DATA;
          mem_re          = 1'b1;
          mem_raddr       = q_op.at_front ? head_r : tail_dec;
          if (q_op.remove) begin
            cnt_nxt = cnt_r - 1'b1;
            if (q_op.at_front) head_nxt = head_inc;
            else               tail_nxt = tail_dec;
          end
        end
      end else begin
        // size request leaves everything as it is
        cnt_nxt = cnt_r;
      end
      pend_count_nxt = COUNT_W'(cnt_nxt);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_EXEC;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // pending result of the request in flight
  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pend_count_r  <= pend_count_nxt;
  end

  // ring memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= wr_word;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= pend_status_r;
      out_count_r  <= pend_count_r;
      out_data_r   <= (pend_status_r == ST_DATA) ? VALUE_W'(rd_data_r) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_count_r, out_data_r, out_status_r};

endmodule

[src/double_ended_queue.sv]
// double_ended_queue: top level of the double-ended queue
// instantiates deq_front, deq_queue and deq_back; depends on deq_pkg
//
// A double-ended queue of up to DEPTH values held in a ring memory. Each
// request on the input stream carries one command (push or pop at either
// end, peek at either end, size, clear) and gives exactly one result
// (status, end value, entry count after the command). A push into a full
// deque or a pop or peek on an empty one returns error and changes nothing.
// A request is accepted into a two-entry queue, then executed against the
// ring, and its result is loaded into the result register that drives
// out_tvalid and out_tdata. Sustained rate is one request per cycle while
// the result side keeps taking; the back end executes the next request
// while the result of the last one is loaded, as the registered read of
// the ring memory keeps a request in the back end for an execute and a
// result step. The ring needs no clearing after reset: entries are only
// read once written.
module double_ended_queue #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] command, [34:3] push_value, zero above
  input  logic [deq_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] status, [33:2] data, [42:34] count, zero above
  output logic [deq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import deq_pkg::*;

  logic q_full;
  logic q_push;
  op_t  q_push_op;
  logic q_pop;
  logic q_not_empty;
  op_t  q_pop_op;

  // request classification
  deq_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (q_push_op)
  );

  // decoupling queue
  deq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_op   (q_push_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_op    (q_pop_op)
  );

  // ring execution and result register
  deq_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_op        (q_pop_op),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

[bench/tb_double_ended_queue.sv]
// tb_double_ended_queue: self-checking bench for the double-ended queue
// drives requests on the input stream and checks every result against the directed table or a ring predictor
// depends on deq_pkg and double_ended_queue
module tb_double_ended_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int STALL_LIMIT = 1000;
  localparam int SHOW_LIMIT  = 10;

  // one result as carried on the output stream
  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   data;
    logic [COUNT_W-1:0]   count;
  } deq_result_t;

  // directed request with its hand-worked result
  typedef struct packed {
    cmd_e_t               cmd;
    logic [VALUE_W-1:0]   value;
    deq_result_t          result;
  } directed_row_t;

  typedef enum {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // predictor state
  logic [VALUE_W-1:0]     deque_slots [DEPTH];
  logic [PTR_W-1:0]       deque_head  = '0;
  logic [PTR_W-1:0]       deque_tail  = '0;
  logic [COUNT_W-1:0]     deque_count = '0;

  deq_result_t            pending_results [$];
  int                     mismatches  = 0;
  int                     idle_pct    = 0;
  int                     stall_left  = 0;
  int                     quiet_cycles = 0;

  // directed requests from reset: empty errors, extremes at both ends, clear
  directed_row_t directed_rows [0:23] = '{
    '{CMD_POP_FRONT,  32'h0000_0000, '{ST_ERROR, 32'h0000_0000, 9'd0}},
    '{CMD_POP_BACK,   32'hFFFF_FFFF, '{ST_ERROR, 32'h0000_0000, 9'd0}},
    '{CMD_FRONT,      32'h0000_0000, '{ST_ERROR, 32'h0000_0000, 9'd0}},
    '{CMD_BACK,       32'h0000_0000, '{ST_ERROR, 32'h0000_0000, 9'd0}},
    '{CMD_SIZE,       32'h0000_0000, '{ST_OK,    32'h0000_0000, 9'd0}},
    '{CMD_PUSH_BACK,  32'h7FFF_FFFF, '{ST_OK,    32'h0000_0000, 9'd1}},
    '{CMD_PUSH_FRONT, 32'h8000_0000, '{ST_OK,    32'h0000_0000, 9'd2}},
    '{CMD_FRONT,      32'h0000_0000, '{ST_DATA,  32'h8000_0000, 9'd2}},
    '{CMD_BACK,       32'h0000_0000, '{ST_DATA,  32'h7FFF_FFFF, 9'd2}},
    '{CMD_PUSH_BACK,  32'hFFFF_FFFF, '{ST_OK,    32'h0000_0000, 9'd3}},
    '{CMD_PUSH_FRONT, 32'h0000_0000, '{ST_OK,    32'h0000_0000, 9'd4}},
    '{CMD_SIZE,       32'hFFFF_FFFF, '{ST_OK,    32'h0000_0000, 9'd4}},
    '{CMD_POP_BACK,   32'h0000_0000, '{ST_DATA,  32'hFFFF_FFFF, 9'd3}},
    '{CMD_POP_FRONT,  32'h0000_0000, '{ST_DATA,  32'h0000_0000, 9'd2}},
    '{CMD_POP_FRONT,  32'h0000_0000, '{ST_DATA,  32'h8000_0000, 9'd1}},
    '{CMD_POP_BACK,   32'h0000_0000, '{ST_DATA,  32'h7FFF_FFFF, 9'd0}},
    '{CMD_POP_BACK,   32'h0000_0000, '{ST_ERROR, 32'h0000_0000, 9'd0}},
    '{CMD_PUSH_FRONT, 32'h1234_5678, '{ST_OK,    32'h0000_0000, 9'd1}},
    '{CMD_PUSH_FRONT, 32'hA5A5_A5A5, '{ST_OK,    32'h0000_0000, 9'd2}},
    '{CMD_CLEAR,      32'h0000_0000, '{ST_OK,    32'h0000_0000, 9'd0}},
    '{CMD_FRONT,      32'h0000_0000, '{ST_ERROR, 32'h0000_0000, 9'd0}},
    '{CMD_PUSH_BACK,  32'h5A5A_5A5A, '{ST_OK,    32'h0000_0000, 9'd1}},
    '{CMD_BACK,       32'h0000_0000, '{ST_DATA,  32'h5A5A_5A5A, 9'd1}},
    '{CMD_CLEAR,      32'hFFFF_FFFF, '{ST_OK,    32'h0000_0000, 9'd0}}
  };

  // random phases: fill runs into the full deque, drain runs it dry, last phase has no idling
  mix_t seg_mix  [0:5] = '{MIX_BALANCED, MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_FILL,
                           MIX_BALANCED};
  int   seg_len  [0:5] = '{200, 330, 330, 200, 140, 150};
  int   seg_idle [0:5] = '{15, 10, 0, 25, 15, 0};

  logic [VALUE_W-1:0] edge_values [0:4] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                           32'hFFFF_FFFF, 32'h0000_0001};

  double_ended_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // ring predictor: applies one command and gives its result
  function automatic deq_result_t apply_command(cmd_e_t cmd, logic [VALUE_W-1:0] value);
    deq_result_t      res;
    logic [PTR_W-1:0] last;
    res.status = ST_OK;
    res.data   = '0;
    last       = deque_tail - 1'b1;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (deque_count == DEPTH) begin
          res.status = ST_ERROR;
        end else if (cmd == CMD_PUSH_FRONT) begin
          deque_head = deque_head - 1'b1;
          deque_slots[deque_head] = value;
          deque_count = deque_count + 1'b1;
        end else begin
          deque_slots[deque_tail] = value;
          deque_tail = deque_tail + 1'b1;
          deque_count = deque_count + 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_FRONT: begin
        if (deque_count == 0) begin
          res.status = ST_ERROR;
        end else begin
          res.status = ST_DATA;
          res.data   = deque_slots[deque_head];
          if (cmd == CMD_POP_FRONT) begin
            deque_head  = deque_head + 1'b1;
            deque_count = deque_count - 1'b1;
          end
        end
      end
      CMD_POP_BACK, CMD_BACK: begin
        if (deque_count == 0) begin
          res.status = ST_ERROR;
        end else begin
          res.status = ST_DATA;
          res.data   = deque_slots[last];
          if (cmd == CMD_POP_BACK) begin
            deque_tail  = last;
            deque_count = deque_count - 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        deque_head  = '0;
        deque_tail  = '0;
        deque_count = '0;
      end
      default: ;
    endcase
    res.count = deque_count;
    return res;
  endfunction

  // command mix per phase
  function automatic cmd_e_t pick_command(mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: if (roll < 90) return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      MIX_DRAIN: if (roll < 90) return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
      default: if (roll < 2) return CMD_CLEAR;
    endcase
    return cmd_e_t'($urandom_range(CMD_PUSH_FRONT, CMD_SIZE));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 9) == 0) return edge_values[$urandom_range(0, 4)];
    return $urandom;
  endfunction

  // present one request from a falling edge, wait for its handshake, record its result
  task automatic send_request(input cmd_e_t cmd, input logic [VALUE_W-1:0] value,
                              input bit use_given, input deq_result_t given);
    deq_result_t predicted;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - VALUE_W - CMD_W){1'b0}}, value, cmd};
    do @(posedge clk); while (!in_tready);
    predicted = apply_command(cmd, value);
    pending_results.insert(pending_results.size(), use_given ? given : predicted);
    @(negedge clk);
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= SHOW_LIMIT) $display("mismatch: %s", msg);
  endtask

  // result side stalls in bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    deq_result_t want;
    deq_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{status_t'(out_tdata[STATUS_W-1:0]), out_tdata[STATUS_W +: VALUE_W],
              out_tdata[STATUS_W+VALUE_W +: COUNT_W]};
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: status %0d data %h count %0d",
                                got.status, got.data, got.count));
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (got.status !== want.status)
          note_mismatch($sformatf("status expected %0d got %0d", want.status, got.status));
        if (got.data !== want.data)
          note_mismatch($sformatf("data expected %h got %h", want.data, got.data));
        if (got.count !== want.count)
          note_mismatch($sformatf("count expected %0d got %0d", want.count, got.count));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus: reset, directed table, random phases, drain
  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    idle_pct = 10;
    foreach (directed_rows[i])
      send_request(directed_rows[i].cmd, directed_rows[i].value, 1'b1,
                   directed_rows[i].result);
    for (int s = 0; s < 6; s++) begin
      idle_pct = seg_idle[s];
      for (int n = 0; n < seg_len[s]; n++)
        send_request(pick_command(seg_mix[s]), pick_value(), 1'b0, '0);
    end
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
